[hdl/rlgfs_pkg.sv]
// ----------------------------------------------------------------------------
// rlgfs_pkg: shared types, constants and gamma table
// Sizes of the LED chain, command and result words, and the gamma curve
// built at elaboration with exact integer arithmetic.
// ----------------------------------------------------------------------------
package rlgfs_pkg;

  localparam int unsigned CHAIN_COUNT   = 2;
  localparam int unsigned LEDS_PER_CHIP = 8;
  localparam int unsigned CH_PER_CHIP   = 24;
  localparam int unsigned LED_TOTAL     = CHAIN_COUNT * LEDS_PER_CHIP;
  localparam int unsigned CH_TOTAL      = CHAIN_COUNT * CH_PER_CHIP;
  localparam int unsigned LED_AW        = $clog2(LED_TOTAL);
  localparam int unsigned CH_AW         = $clog2(CH_TOTAL);
  localparam int unsigned LANE_W        = $clog2(LEDS_PER_CHIP);

  localparam int unsigned GRAY_W        = 12;
  localparam logic [GRAY_W-1:0] GRAY_MAX = 12'hFFF;

  localparam int unsigned GAMMA_W       = 11;
  localparam int unsigned GAMMA_DEPTH   = 256;
  localparam int unsigned PWM_FULL      = 1024;

  typedef enum logic [2:0] {
    OP_SET_LED   = 3'd0,
    OP_SET_CH    = 3'd1,
    OP_SET_ALL   = 3'd2,
    OP_FLUSH     = 3'd3,
    OP_UPDATE    = 3'd4,
    OP_CLEAR_RGB = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    COL_RED   = 2'd0,
    COL_GREEN = 2'd1,
    COL_BLUE  = 2'd2
  } col_sel_e;

  localparam logic KIND_STATUS    = 1'b0;
  localparam logic KIND_WORD      = 1'b1;
  localparam logic STAT_OK        = 1'b0;
  localparam logic STAT_BAD_INDEX = 1'b1;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [5:0]  index;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] gray_level;
  } cmd_t;

  typedef struct packed {
    logic        kind;
    logic        status;
    logic [23:0] frame_word;
    logic        last;
  } res_t;

  // one lookup request to the map unit
  typedef struct packed {
    logic              valid;
    logic [LED_AW-1:0] led;
    col_sel_e          sel;
    logic [7:0]        level;
  } map_req_t;

  // gray store write port
  typedef struct packed {
    logic              en;
    logic [CH_AW-1:0]  addr;
    logic [GRAY_W-1:0] data;
  } gray_wr_t;

  typedef logic [GAMMA_DEPTH-1:0][GAMMA_W-1:0] gamma_rom_t;

  function automatic logic [255:0] big_pow(input logic [255:0] b, input int unsigned e);
    logic [255:0] acc;
    acc = 256'd1;
    for (int unsigned k = 0; k < e; k++) begin
      acc = acc * b;
    end
    return acc;
  endfunction

  // largest n with (2n-1)^5 * 255^21 <= 2^55 * i^21, capped at full scale
  function automatic logic [GAMMA_W-1:0] gamma_entry(input int unsigned i);
    logic [255:0] den;
    logic [255:0] rhs;
    logic [255:0] lhs;
    int unsigned  n;
    int unsigned  cand;
    den = big_pow(256'd255, 21);
    rhs = big_pow(256'(i), 21) << 55;
    n   = 0;
    for (int b = GAMMA_W - 1; b >= 0; b--) begin
      cand = n + (32'd1 << b);
      if (cand <= PWM_FULL) begin
        lhs = big_pow(256'(2 * cand - 1), 5) * den;
        if (lhs <= rhs) begin
          n = cand;
        end
      end
    end
    if (i == GAMMA_DEPTH - 1) begin
      n = PWM_FULL;
    end
    return GAMMA_W'(n);
  endfunction

  function automatic gamma_rom_t build_gamma();
    gamma_rom_t rom;
    for (int unsigned i = 0; i < GAMMA_DEPTH; i++) begin
      rom[i] = gamma_entry(i);
    end
    return rom;
  endfunction

  localparam gamma_rom_t GAMMA_ROM = build_gamma();

endpackage

[hdl/rlgfs_gray_mem.sv]
// ----------------------------------------------------------------------------
// rlgfs_gray_mem: 12-bit grayscale store
// One write port, two registered read ports; per-entry valid bits make
// unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
module rlgfs_gray_mem
  import rlgfs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gray_wr_t          wr_i,
  input  logic [CH_AW-1:0]  rd_lo_addr_i,
  input  logic [CH_AW-1:0]  rd_hi_addr_i,
  output logic [GRAY_W-1:0] rd_lo_o,
  output logic [GRAY_W-1:0] rd_hi_o
);

  logic [GRAY_W-1:0] mem_q [CH_TOTAL];
  logic [CH_TOTAL-1:0] vld_q;
  logic [GRAY_W-1:0] rd_lo_q;
  logic [GRAY_W-1:0] rd_hi_q;
  logic              rd_lo_vld_q;
  logic              rd_hi_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      rd_lo_vld_q <= 1'b0;
      rd_hi_vld_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        vld_q[wr_i.addr] <= 1'b1;
      end
      rd_lo_vld_q <= vld_q[rd_lo_addr_i];
      rd_hi_vld_q <= vld_q[rd_hi_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    rd_lo_q <= mem_q[rd_lo_addr_i];
    rd_hi_q <= mem_q[rd_hi_addr_i];
  end

  assign rd_lo_o = rd_lo_vld_q ? rd_lo_q : '0;
  assign rd_hi_o = rd_hi_vld_q ? rd_hi_q : '0;

endmodule

[hdl/rlgfs_map_unit.sv]
// ----------------------------------------------------------------------------
// rlgfs_map_unit: shared gamma and channel-map unit
// Takes one colour byte of one LED per cycle, looks it up in the gamma
// table and works out its grayscale channel; the write is registered.
// ----------------------------------------------------------------------------
module rlgfs_map_unit
  import rlgfs_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  map_req_t req_i,
  output gray_wr_t wr_o
);

  logic [CH_AW-1:0]  base;
  logic [LANE_W-1:0] lane;
  logic [CH_AW-1:0]  rg_ch;
  logic [CH_AW-1:0]  ch_d;
  logic [GRAY_W-1:0] level_d;

  logic              en_q;
  logic [CH_AW-1:0]  ch_q;
  logic [GRAY_W-1:0] level_q;

  always_comb begin
    base  = CH_AW'((req_i.led / LEDS_PER_CHIP) * CH_PER_CHIP);
    lane  = LANE_W'(req_i.led % LEDS_PER_CHIP);
    // red/green pairs run downward from local channel 22
    rg_ch = base + CH_AW'(LEDS_PER_CHIP)
          + CH_AW'({LANE_W'(LEDS_PER_CHIP - 1) - lane, 1'b0});
    unique case (req_i.sel)
      COL_RED:   ch_d = rg_ch;
      COL_GREEN: ch_d = rg_ch + CH_AW'(1);
      COL_BLUE:  ch_d = base + CH_AW'(lane);
      default:   ch_d = base + CH_AW'(lane);
    endcase
    level_d = GRAY_W'(GAMMA_ROM[req_i.level]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q <= 1'b0;
    end else begin
      en_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q    <= ch_d;
    level_q <= level_d;
  end

  assign wr_o = '{en: en_q, addr: ch_q, data: level_q};

endmodule

[hdl/rgb_led_gamma_frame_serializer.sv]
// ----------------------------------------------------------------------------
// rgb_led_gamma_frame_serializer: LED colour / grayscale frame engine
// Holds an RGB store and a 12-bit grayscale store for a chain of 24-channel
// PWM driver chips, maps colours through a gamma curve and streams frames.
// ----------------------------------------------------------------------------
//
//  channel   | handshake            | payload
//  ----------+----------------------+-----------------------------------
//  command   | start_i / busy_o     | cmd_i (opcode, index, rgb, gray)
//  result    | res_valid_o (strobe) | res_o (kind, status, word, last)
//
//  Set LED, set channel, clear RGB and unused opcodes: status word in the
//    next cycle, busy stays low.
//  Set all: one gray store write per cycle across all CH_TOTAL channels.
//  Flush: one word per cycle, highest pair first, behind the registered
//    gray store read and the result register.
//  Update: all three colour bytes of every LED through the shared map unit,
//    one gamma lookup and one gray store write each, then the drain state and a flush.
//  Reset: both stores read as zero through valid bits, no clearing pass.
//  The receiver cannot stall; each result word shows for one cycle.
//
module rgb_led_gamma_frame_serializer
  import rlgfs_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  cmd_t cmd_i,
  output logic busy_o,
  output logic res_valid_o,
  output res_t res_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_MAP,
    ST_DRAIN,
    ST_FLUSH,
    ST_WAIT
  } state_e;

  state_e            state_q;
  logic [CH_AW-1:0]  fill_cnt_q;
  logic [GRAY_W-1:0] fill_val_q;
  logic [LED_AW-1:0] map_led_q;
  col_sel_e          map_sel_q;
  logic [CH_AW-1:0]  flush_lo_q;
  logic              rd_pend_q;
  logic              rd_last_q;
  logic              res_valid_q;
  res_t              res_q;

  // RGB store: red<<16 | green<<8 | blue
  logic [23:0]          rgb_q [LED_TOTAL];
  logic [LED_TOTAL-1:0] rgb_vld_q;
  logic [23:0]          rgb_cur;

  logic              accept;
  op_e               op;
  logic              led_ok;
  logic              ch_ok;
  logic [GRAY_W-1:0] gray_clip;
  logic              rgb_wr;
  logic              rgb_clr;

  map_req_t          map_req;
  gray_wr_t          map_wr;
  gray_wr_t          gray_wr;
  logic [GRAY_W-1:0] rd_lo;
  logic [GRAY_W-1:0] rd_hi;

  assign busy_o      = (state_q != ST_IDLE);
  assign accept      = start_i && !busy_o;
  assign op          = op_e'(cmd_i.opcode);
  assign led_ok      = (32'(cmd_i.index) < LED_TOTAL);
  assign ch_ok       = (32'(cmd_i.index) < CH_TOTAL);
  assign gray_clip   = (cmd_i.gray_level > 16'(GRAY_MAX)) ? GRAY_MAX
                                                          : cmd_i.gray_level[GRAY_W-1:0];
  assign rgb_wr      = accept && (op == OP_SET_LED) && led_ok;
  assign rgb_clr     = accept && (op == OP_CLEAR_RGB);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // --- RGB store ------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rgb_vld_q <= '0;
    end else if (rgb_clr) begin
      rgb_vld_q <= '0;
    end else if (rgb_wr) begin
      rgb_vld_q[LED_AW'(cmd_i.index)] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rgb_wr) begin
      rgb_q[LED_AW'(cmd_i.index)] <= {cmd_i.red, cmd_i.green, cmd_i.blue};
    end
  end

  assign rgb_cur = rgb_vld_q[map_led_q] ? rgb_q[map_led_q] : '0;

  // --- shared map unit: one colour byte per cycle ---------------------------
  always_comb begin
    map_req.valid = (state_q == ST_MAP);
    map_req.led   = map_led_q;
    map_req.sel   = map_sel_q;
    unique case (map_sel_q)
      COL_RED:   map_req.level = rgb_cur[23:16];
      COL_GREEN: map_req.level = rgb_cur[15:8];
      COL_BLUE:  map_req.level = rgb_cur[7:0];
      default:   map_req.level = rgb_cur[7:0];
    endcase
  end

  rlgfs_map_unit u_map (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (map_req),
    .wr_o   (map_wr)
  );

  // --- gray store write port: map unit, fill sweep or single write ---------
  always_comb begin
    priority if (map_wr.en) begin
      gray_wr = map_wr;
    end else if (state_q == ST_FILL) begin
      gray_wr = '{en: 1'b1, addr: fill_cnt_q, data: fill_val_q};
    end else if (accept && (op == OP_SET_CH) && ch_ok) begin
      gray_wr = '{en: 1'b1, addr: CH_AW'(cmd_i.index), data: gray_clip};
    end else begin
      gray_wr = '{en: 1'b0, addr: '0, data: '0};
    end
  end

  // flush reads one channel pair a cycle, highest pair first
  rlgfs_gray_mem u_gray (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_i         (gray_wr),
    .rd_lo_addr_i (flush_lo_q),
    .rd_hi_addr_i (flush_lo_q + CH_AW'(1)),
    .rd_lo_o      (rd_lo),
    .rd_hi_o      (rd_hi)
  );

  // --- sequencer and result register ----------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_cnt_q  <= '0;
      fill_val_q  <= '0;
      map_led_q   <= '0;
      map_sel_q   <= COL_RED;
      flush_lo_q  <= '0;
      rd_pend_q   <= 1'b0;
      rd_last_q   <= 1'b0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      res_valid_q <= 1'b0;
      rd_pend_q   <= 1'b0;

      // frame word from the read issued in ST_FLUSH, through the registered store read
      if (rd_pend_q) begin
        res_valid_q <= 1'b1;
        res_q       <= '{kind: KIND_WORD, status: STAT_OK,
                         frame_word: {rd_hi, rd_lo}, last: rd_last_q};
      end

      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            unique case (op)
              OP_SET_LED: begin
                res_valid_q <= 1'b1;
                res_q <= '{kind: KIND_STATUS,
                           status: led_ok ? STAT_OK : STAT_BAD_INDEX,
                           frame_word: '0, last: 1'b1};
              end
              OP_SET_CH: begin
                res_valid_q <= 1'b1;
                res_q <= '{kind: KIND_STATUS,
                           status: ch_ok ? STAT_OK : STAT_BAD_INDEX,
                           frame_word: '0, last: 1'b1};
              end
              OP_SET_ALL: begin
                fill_cnt_q <= '0;
                fill_val_q <= gray_clip;
                state_q    <= ST_FILL;
              end
              OP_FLUSH: begin
                flush_lo_q <= CH_AW'(CH_TOTAL - 2);
                state_q    <= ST_FLUSH;
              end
              OP_UPDATE: begin
                map_led_q <= '0;
                map_sel_q <= COL_RED;
                state_q   <= ST_MAP;
              end
              default: begin
                // clear RGB and the unused opcodes: plain ok status
                res_valid_q <= 1'b1;
                res_q <= '{kind: KIND_STATUS, status: STAT_OK,
                           frame_word: '0, last: 1'b1};
              end
            endcase
          end
        end

        ST_FILL: begin
          if (fill_cnt_q == CH_AW'(CH_TOTAL - 1)) begin
            res_valid_q <= 1'b1;
            res_q <= '{kind: KIND_STATUS, status: STAT_OK,
                       frame_word: '0, last: 1'b1};
            state_q <= ST_IDLE;
          end else begin
            fill_cnt_q <= fill_cnt_q + CH_AW'(1);
          end
        end

        ST_MAP: begin
          unique case (map_sel_q)
            COL_RED:   map_sel_q <= COL_GREEN;
            COL_GREEN: map_sel_q <= COL_BLUE;
            default: begin
              map_sel_q <= COL_RED;
              if (map_led_q == LED_AW'(LED_TOTAL - 1)) begin
                state_q <= ST_DRAIN;
              end else begin
                map_led_q <= map_led_q + LED_AW'(1);
              end
            end
          endcase
        end

        ST_DRAIN: begin
          // last map write lands before the first flush read
          flush_lo_q <= CH_AW'(CH_TOTAL - 2);
          state_q    <= ST_FLUSH;
        end

        ST_FLUSH: begin
          rd_pend_q <= 1'b1;
          rd_last_q <= (flush_lo_q == '0);
          if (flush_lo_q == '0) begin
            state_q <= ST_WAIT;
          end else begin
            flush_lo_q <= flush_lo_q - CH_AW'(2);
          end
        end

        ST_WAIT: begin
          if (!rd_pend_q) begin
            state_q <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // --- assertions -----------------------------------------------------------
  a_word_in_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (res_o.kind == KIND_WORD) |-> (state_q == ST_FLUSH || state_q == ST_WAIT))
    else $error("frame word outside a flush");

  a_pend_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> busy_o)
    else $error("idle with a frame read in flight");

  a_wr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gray_wr.en |-> (32'(gray_wr.addr) < CH_TOTAL))
    else $error("gray write beyond store");

  a_status_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (res_o.kind == KIND_STATUS) |-> res_o.last && (res_o.frame_word == '0))
    else $error("malformed status word");

  a_frame_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (cmd_i.opcode == 3'(OP_FLUSH) || cmd_i.opcode == 3'(OP_UPDATE)) |=> busy_o)
    else $error("frame command did not raise busy");

endmodule

[bench/tb_rgb_led_gamma_frame_serializer.sv]
// ----------------------------------------------------------------------------
// tb_rgb_led_gamma_frame_serializer: self-checking bench for the frame engine
// Walks a short directed table of commands, then random command words with
// idle bursts. A behavioural copy of both stores and the gamma curve predicts
// every status and frame word, and each strobed result is checked in order.
// ----------------------------------------------------------------------------
module tb_rgb_led_gamma_frame_serializer;
  timeunit 1ns;
  timeprecision 1ps;

  import rlgfs_pkg::*;

  // opcodes the block must ignore (status ok, nothing changed)
  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;

  localparam int unsigned FRAME_WORDS  = CH_TOTAL / 2;
  localparam int unsigned RANDOM_CMDS  = 156;
  localparam int unsigned QUIET_TAIL   = 30;    // last commands sent back to back
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  localparam res_t RES_OK      = '{KIND_STATUS, STAT_OK, 24'd0, 1'b1};
  localparam res_t RES_BAD_IDX = '{KIND_STATUS, STAT_BAD_INDEX, 24'd0, 1'b1};

  typedef struct {
    cmd_t cmd;
    bit   typed;  // use the typed-in status word below instead of the prediction
    res_t want;
  } row_t;

  logic clk_i;
  logic rst_ni;
  logic start_i;
  cmd_t cmd_i;
  logic busy_o;
  logic res_valid_o;
  res_t res_o;

  // predictor state
  logic [23:0]        led_rgb   [LED_TOTAL];
  logic [GRAY_W-1:0]  ch_gray   [CH_TOTAL];
  logic [GAMMA_W-1:0] gamma_lut [GAMMA_DEPTH];
  res_t               owed_res  [$];

  int unsigned mismatches = 0;
  int unsigned words_seen = 0;
  int unsigned cycle_cnt  = 0;
  int unsigned op_count   [8];

  rgb_led_gamma_frame_serializer u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .cmd_i       (cmd_i),
    .busy_o      (busy_o),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  task automatic report(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatches++;
  endtask

  // Gamma curve with exact integers: n is the largest value with
  // (2n-1)^5 * 255^21 <= 2^55 * i^21. The curve is monotone, so the walk
  // carries n from one entry to the next. Top entry pinned to full scale.
  task automatic fill_gamma_lut();
    logic [255:0] den;
    logic [255:0] rhs;
    logic [255:0] lhs;
    int unsigned  n;
    den = 256'd1;
    repeat (21) den = den * 256'd255;
    n = 0;
    gamma_lut[0] = '0;
    for (int unsigned i = 1; i < GAMMA_DEPTH; i++) begin
      rhs = 256'd1;
      repeat (21) rhs = rhs * 256'(i);
      rhs = rhs << 55;
      while (n < PWM_FULL) begin
        lhs = den;
        repeat (5) lhs = lhs * 256'(2 * n + 1);
        if (lhs > rhs) break;
        n++;
      end
      gamma_lut[i] = GAMMA_W'(n);
    end
    gamma_lut[GAMMA_DEPTH-1] = GAMMA_W'(PWM_FULL);
  endtask

  // Applies one accepted command to the predicted stores and queues the
  // words it owes: a status word, or a full frame for flush and update.
  task automatic apply_command(input cmd_t c, input bit typed, input res_t want);
    res_t              r;
    logic [GRAY_W-1:0] g;
    int unsigned       base;
    int unsigned       lane;
    int unsigned       rg;
    bit                framed;
    r      = RES_OK;
    framed = 1'b0;
    g      = (c.gray_level > GRAY_MAX) ? GRAY_MAX : c.gray_level[GRAY_W-1:0];
    case (c.opcode)
      OP_SET_LED: begin
        if (c.index < LED_TOTAL) led_rgb[c.index] = {c.red, c.green, c.blue};
        else r.status = STAT_BAD_INDEX;
      end
      OP_SET_CH: begin
        if (c.index < CH_TOTAL) ch_gray[c.index] = g;
        else r.status = STAT_BAD_INDEX;
      end
      OP_SET_ALL: begin
        foreach (ch_gray[i]) ch_gray[i] = g;
      end
      OP_CLEAR_RGB: begin
        foreach (led_rgb[i]) led_rgb[i] = '0;
      end
      OP_UPDATE, OP_FLUSH: begin
        framed = 1'b1;
        if (c.opcode == OP_UPDATE) begin
          // blue on local lane n, red/green pair counts down from channel 22
          for (int unsigned l = 0; l < LED_TOTAL; l++) begin
            base = (l / LEDS_PER_CHIP) * CH_PER_CHIP;
            lane = l % LEDS_PER_CHIP;
            rg   = base + 8 + 2 * (7 - lane);
            ch_gray[rg]     = GRAY_W'(gamma_lut[led_rgb[l][23:16]]);
            ch_gray[rg + 1] = GRAY_W'(gamma_lut[led_rgb[l][15:8]]);
            ch_gray[base + lane] = GRAY_W'(gamma_lut[led_rgb[l][7:0]]);
          end
        end
        for (int unsigned k = 0; k < FRAME_WORDS; k++) begin
          r.kind       = KIND_WORD;
          r.status     = STAT_OK;
          r.frame_word = {ch_gray[CH_TOTAL - 1 - 2 * k], ch_gray[CH_TOTAL - 2 - 2 * k]};
          r.last       = (k == FRAME_WORDS - 1);
          owed_res.push_back(r);
        end
      end
      default: ;
    endcase
    if (!framed) owed_res.push_back(typed ? want : r);
    op_count[c.opcode]++;
  endtask

  function automatic cmd_t mk(input logic [2:0] op, input logic [5:0] idx,
                              input logic [7:0] r, input logic [7:0] g,
                              input logic [7:0] b, input logic [15:0] gl);
    cmd_t c;
    c = '{op, idx, r, g, b, gl};
    return c;
  endfunction

  // Random command word: mostly well-formed, indexes mostly in range, gray
  // levels biased towards the clip point, colours now and then at the rails.
  function automatic cmd_t rand_cmd();
    cmd_t        c;
    int unsigned pick;
    c.opcode     = 3'($urandom);
    c.index      = 6'($urandom);
    c.red        = 8'($urandom);
    c.green      = 8'($urandom);
    c.blue       = 8'($urandom);
    c.gray_level = 16'($urandom);
    pick = $urandom_range(99);
    if (pick < 30)      c.opcode = OP_SET_LED;
    else if (pick < 55) c.opcode = OP_SET_CH;
    else if (pick < 61) c.opcode = OP_SET_ALL;
    else if (pick < 73) c.opcode = OP_FLUSH;
    else if (pick < 85) c.opcode = OP_UPDATE;
    else if (pick < 90) c.opcode = OP_CLEAR_RGB;
    // otherwise keep the raw draw, spare opcodes included
    if ($urandom_range(9) != 0) begin
      if (c.opcode == OP_SET_LED)     c.index = 6'($urandom_range(LED_TOTAL - 1));
      else if (c.opcode == OP_SET_CH) c.index = 6'($urandom_range(CH_TOTAL - 1));
    end
    case ($urandom_range(9))
      0:       c.gray_level = 16'd0;
      1:       c.gray_level = 16'hFFFF;
      2:       c.gray_level = 16'(GRAY_MAX);
      3:       c.gray_level = 16'(GRAY_MAX) + 16'd1;
      4, 5:    ;
      default: c.gray_level = 16'($urandom_range(GRAY_MAX));
    endcase
    if ($urandom_range(4) == 0) c.red   = {8{c.red[0]}};
    if ($urandom_range(4) == 0) c.green = {8{c.green[0]}};
    if ($urandom_range(4) == 0) c.blue  = {8{c.blue[0]}};
    return c;
  endfunction

  // Holds the word on the port until the block takes it. Start is left high
  // so a following word can go out back to back.
  task automatic issue(input cmd_t c, input bit typed, input res_t want);
    @(negedge clk_i);
    start_i = 1'b1;
    cmd_i   = c;
    forever begin
      @(posedge clk_i);
      if (!busy_o) break;
    end
    apply_command(c, typed, want);
  endtask

  // start low with junk on the command bus, repeated n times
  task automatic rest(input int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      start_i = 1'b0;
      cmd_i   = rand_cmd();
    end
  endtask

  task automatic drain();
    rest(1);
    while (owed_res.size() != 0) @(posedge clk_i);
  endtask

  // result checker: every strobed word against the oldest owed word
  always @(posedge clk_i) begin : check_res
    res_t want;
    if (rst_ni && res_valid_o) begin
      words_seen++;
      if (owed_res.size() == 0) begin
        report($sformatf("result word %h with nothing owed", res_o));
      end else begin
        want = owed_res.pop_front();
        if (res_o.kind !== want.kind)
          report($sformatf("kind %b, want %b", res_o.kind, want.kind));
        if (res_o.status !== want.status)
          report($sformatf("status %b, want %b", res_o.status, want.status));
        if (res_o.frame_word !== want.frame_word)
          report($sformatf("frame word %h, want %h", res_o.frame_word, want.frame_word));
        if (res_o.last !== want.last)
          report($sformatf("last %b, want %b", res_o.last, want.last));
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still owed", cycle_cnt, owed_res.size());
      $display("tb_rgb_led_gamma_frame_serializer NOT OK");
      $finish;
    end
  end

  initial begin
    row_t plan[$];
    start_i = 1'b0;
    cmd_i   = '0;
    rst_ni  = 1'b0;
    foreach (led_rgb[i]) led_rgb[i] = '0;
    foreach (ch_gray[i]) ch_gray[i] = '0;
    foreach (op_count[i]) op_count[i] = 0;
    fill_gamma_lut();

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed table: rails of every field, every opcode, bad indexes,
    // gray clipping, and the unused opcodes
    plan.push_back('{mk(OP_FLUSH,     0, 8'h00, 8'h00, 8'h00, 16'h0000), 1'b0, RES_OK});
    plan.push_back('{mk(OP_SET_LED,   0, 8'hFF, 8'h00, 8'h80, 16'h0000), 1'b1, RES_OK});
    plan.push_back('{mk(OP_SET_LED,  15, 8'h00, 8'hFF, 8'h01, 16'hFFFF), 1'b1, RES_OK});
    plan.push_back('{mk(OP_SET_LED,  16, 8'h12, 8'h34, 8'h56, 16'h0000), 1'b1, RES_BAD_IDX});
    plan.push_back('{mk(OP_SET_LED,  63, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF), 1'b1, RES_BAD_IDX});
    plan.push_back('{mk(OP_SET_LED,   7, 8'h01, 8'h02, 8'hFE, 16'h0000), 1'b0, RES_OK});
    plan.push_back('{mk(OP_SET_LED,   8, 8'hFF, 8'hFF, 8'hFF, 16'h0000), 1'b0, RES_OK});
    plan.push_back('{mk(OP_UPDATE,    0, 8'h00, 8'h00, 8'h00, 16'h0000), 1'b0, RES_OK});
    plan.push_back('{mk(OP_SET_CH,    0, 8'h00, 8'h00, 8'h00, 16'h0000), 1'b1, RES_OK});
    plan.push_back('{mk(OP_SET_CH,   47, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF), 1'b1, RES_OK});
    plan.push_back('{mk(OP_SET_CH,   48, 8'h00, 8'h00, 8'h00, 16'h0123), 1'b1, RES_BAD_IDX});
    plan.push_back('{mk(OP_SET_CH,   63, 8'h00, 8'h00, 8'h00, 16'h0FFF), 1'b1, RES_BAD_IDX});
    plan.push_back('{mk(OP_SET_CH,   23, 8'h00, 8'h00, 8'h00, 16'h0FFF), 1'b0, RES_OK});
    plan.push_back('{mk(OP_SET_CH,   24, 8'h00, 8'h00, 8'h00, 16'h1000), 1'b0, RES_OK});
    plan.push_back('{mk(OP_SET_CH,    1, 8'h00, 8'h00, 8'h00, 16'h0555), 1'b0, RES_OK});
    plan.push_back('{mk(OP_FLUSH,     0, 8'h00, 8'h00, 8'h00, 16'h0000), 1'b0, RES_OK});
    plan.push_back('{mk(OP_SET_ALL,   0, 8'h00, 8'h00, 8'h00, 16'h05A5), 1'b1, RES_OK});
    plan.push_back('{mk(OP_FLUSH,    63, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF), 1'b0, RES_OK});
    plan.push_back('{mk(OP_SET_ALL,   0, 8'h00, 8'h00, 8'h00, 16'hFFFF), 1'b1, RES_OK});
    plan.push_back('{mk(OP_FLUSH,     0, 8'h00, 8'h00, 8'h00, 16'h0000), 1'b0, RES_OK});
    plan.push_back('{mk(OP_CLEAR_RGB, 0, 8'h00, 8'h00, 8'h00, 16'h0000), 1'b1, RES_OK});
    plan.push_back('{mk(OP_UPDATE,    0, 8'h00, 8'h00, 8'h00, 16'h0000), 1'b0, RES_OK});
    plan.push_back('{mk(OP_SPARE_A,   5, 8'hAA, 8'h55, 8'hAA, 16'h5555), 1'b1, RES_OK});
    plan.push_back('{mk(OP_SPARE_B,  40, 8'h55, 8'hAA, 8'h55, 16'hAAAA), 1'b1, RES_OK});

    foreach (plan[i]) begin
      issue(plan[i].cmd, plan[i].typed, plan[i].want);
      if ($urandom_range(2) == 0) rest($urandom_range(10, 1));
    end

    // random words; one full stop half way, then a quiet back-to-back tail
    for (int unsigned n = 0; n < RANDOM_CMDS; n++) begin
      if (n == RANDOM_CMDS / 2) drain();
      issue(rand_cmd(), 1'b0, RES_OK);
      if (n < RANDOM_CMDS - QUIET_TAIL && $urandom_range(9) < 3)
        rest($urandom_range(10, 1));
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered: set-led %0d, set-channel %0d, set-all %0d, flush %0d, update %0d,",
             op_count[OP_SET_LED], op_count[OP_SET_CH], op_count[OP_SET_ALL],
             op_count[OP_FLUSH], op_count[OP_UPDATE]);
    $display("  clear %0d, spare %0d; %0d result words checked, %0d mismatches",
             op_count[OP_CLEAR_RGB], op_count[OP_SPARE_A] + op_count[OP_SPARE_B],
             words_seen, mismatches);
    if (mismatches == 0) begin
      $display("tb_rgb_led_gamma_frame_serializer OK");
    end else begin
      $display("tb_rgb_led_gamma_frame_serializer NOT OK");
    end
    $finish;
  end

endmodule
